@@ rtl/core/fdcc_pkg.sv @@
// Package for the fan duty-cycle controller core.
// Holds the phase and event codes, the register indexes and the structs shared by the engine, top level and testbench.
// No dependencies.
package fdcc_pkg;

   typedef enum logic [1:0] {
      PHASE_DISABLED = 2'd0,
      PHASE_COOLDOWN = 2'd1,
      PHASE_RUNNING  = 2'd2,
      PHASE_PAUSED   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_OBSTACLE  = 2'd1,
      FUNC_TURN_DONE = 2'd2,
      FUNC_FORCE_OFF = 2'd3
   } func_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STARTED           = 3'd0,
      CSR_RELAY_ACTIVE_HIGH = 3'd1,
      CSR_COOLDOWN_MS       = 3'd2,
      CSR_RUN_MS            = 3'd3,
      CSR_AUTO_MODE_CODE    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  mode;
      logic [31:0] now_ms;
   } event_type;

   typedef struct packed {
      logic        started;
      logic [31:0] cooldown_ms;
      logic [31:0] run_ms;
      logic [7:0]  auto_mode_code;
   } timing_cfg_type;

endpackage

@@ rtl/core/fdcc_if.sv @@
// Valid/ready channel interfaces of the fan duty-cycle controller core.
// Depends on nothing; payload widths follow the event and result fields.
interface fdcc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  mode;
   logic [31:0] now_ms;

   modport source (output valid, output func, output mode, output now_ms, input ready);
   modport sink   (input valid, input func, input mode, input now_ms, output ready);
endinterface

interface fdcc_rsp_if;
   logic       valid;
   logic       ready;
   logic       relay_level;
   logic [1:0] fan_state;

   modport source (output valid, output relay_level, output fan_state, input ready);
   modport sink   (input valid, input relay_level, input fan_state, output ready);
endinterface

@@ rtl/core/fdcc_engine.sv @@
// Phase state machine of the fan duty-cycle controller.
// Holds phase, phase start time and the armed resume; uses fdcc_pkg.
module fdcc_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    clear,
   input  fdcc_pkg::event_type      item,
   input  fdcc_pkg::timing_cfg_type cfg,
   output fdcc_pkg::phase_type      phase_next
);

   fdcc_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         start_ff, start_in;
   logic                pend_ff, pend_in;
   logic [31:0]         elapsed;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fdcc_pkg::PHASE_DISABLED;
         start_ff <= 32'd0;
         pend_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      pend_in  = pend_ff;
      // Wrapping subtraction gives the elapsed time across a timer rollover.
      elapsed  = item.now_ms - start_ff;
      if (clear) begin
         phase_in = fdcc_pkg::PHASE_DISABLED;
         start_in = 32'd0;
         pend_in  = 1'b0;
      end else if (step && cfg.started) begin
         unique case (fdcc_pkg::func_type'(item.func))
            fdcc_pkg::FUNC_TICK: begin
               if (item.mode != cfg.auto_mode_code) begin
                  phase_in = fdcc_pkg::PHASE_DISABLED;
                  start_in = 32'd0;
                  pend_in  = 1'b0;
               end else begin
                  unique case (phase_ff)
                     fdcc_pkg::PHASE_DISABLED: begin
                        phase_in = fdcc_pkg::PHASE_COOLDOWN;
                        start_in = item.now_ms;
                     end
                     fdcc_pkg::PHASE_PAUSED: begin
                        if (pend_ff) begin
                           pend_in  = 1'b0;
                           phase_in = fdcc_pkg::PHASE_COOLDOWN;
                           start_in = item.now_ms;
                        end
                     end
                     fdcc_pkg::PHASE_COOLDOWN: begin
                        if (elapsed >= cfg.cooldown_ms) begin
                           phase_in = fdcc_pkg::PHASE_RUNNING;
                           start_in = item.now_ms;
                        end
                     end
                     default: begin
                        if (elapsed >= cfg.run_ms) begin
                           phase_in = fdcc_pkg::PHASE_COOLDOWN;
                           start_in = item.now_ms;
                        end
                     end
                  endcase
               end
            end
            fdcc_pkg::FUNC_OBSTACLE: begin
               if (phase_ff != fdcc_pkg::PHASE_DISABLED) begin
                  pend_in  = 1'b0;
                  phase_in = fdcc_pkg::PHASE_PAUSED;
                  start_in = item.now_ms;
               end
            end
            fdcc_pkg::FUNC_TURN_DONE: begin
               if (phase_ff == fdcc_pkg::PHASE_PAUSED) begin
                  pend_in = 1'b1;
               end
            end
            default: begin
               phase_in = fdcc_pkg::PHASE_DISABLED;
               start_in = 32'd0;
               pend_in  = 1'b0;
            end
         endcase
      end
   end

   assign phase_next = phase_in;

endmodule

@@ rtl/core/fan_duty_cycle_controller_core.sv @@
// Top level of the fan duty-cycle controller core.
// Uses fdcc_pkg, the channels in fdcc_if and the phase machine fdcc_engine.
//
//   channel   direction   handshake        payload
//   req_ch    in          valid / ready    func, mode, now_ms
//   rsp_ch    out         valid / ready    relay_level, fan_state
//   csr_*     in          csr_we only      csr_index, csr_wdata
//
// Every event yields one result; one event is taken per cycle when the result side keeps up.
// An event passes through an input register, then the phase update feeding the result register.
// The phase update is a 32-bit subtract and compare, which sets the cycle time.
// Reset is synchronous and clears the valid flags, settings and phase, not the data registers.
// A stalled result holds the result register; the input register still takes one more transfer.
module fan_duty_cycle_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   fdcc_req_if.sink                            req_ch,
   fdcc_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [fdcc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fdcc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   fdcc_pkg::timing_cfg_type cfg_ff;
   logic                     polarity_ff;

   logic                     in_valid_ff;
   fdcc_pkg::event_type      in_item_ff;
   logic                     out_valid_ff;
   logic                     relay_ff;
   fdcc_pkg::phase_type      state_ff;

   logic                     out_take;
   logic                     advance;
   logic                     clear;
   fdcc_pkg::phase_type      phase_next;

   assign out_take     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_take;
   assign req_ch.ready = !in_valid_ff || out_take;
   assign clear        = csr_we && (fdcc_pkg::csr_index_type'(csr_index) == fdcc_pkg::CSR_STARTED)
                         && csr_wdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.started        <= 1'b0;
         cfg_ff.cooldown_ms    <= 32'd0;
         cfg_ff.run_ms         <= 32'd0;
         cfg_ff.auto_mode_code <= 8'd0;
         polarity_ff           <= 1'b1;
      end else if (csr_we) begin
         unique case (fdcc_pkg::csr_index_type'(csr_index))
            fdcc_pkg::CSR_STARTED:           cfg_ff.started        <= csr_wdata[0];
            fdcc_pkg::CSR_RELAY_ACTIVE_HIGH: polarity_ff           <= csr_wdata[0];
            fdcc_pkg::CSR_COOLDOWN_MS:       cfg_ff.cooldown_ms    <= csr_wdata[31:0];
            fdcc_pkg::CSR_RUN_MS:            cfg_ff.run_ms         <= csr_wdata[31:0];
            fdcc_pkg::CSR_AUTO_MODE_CODE:    cfg_ff.auto_mode_code <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_take) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.func   <= req_ch.func;
         in_item_ff.mode   <= req_ch.mode;
         in_item_ff.now_ms <= req_ch.now_ms;
      end
      if (advance) begin
         state_ff <= phase_next;
         relay_ff <= ((phase_next == fdcc_pkg::PHASE_RUNNING) == polarity_ff);
      end
   end

   fdcc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .clear      (clear),
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .phase_next (phase_next)
   );

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.relay_level = relay_ff;
   assign rsp_ch.fan_state   = state_ff;

endmodule

@@ rtl/core/fdcc_checker.sv @@
// Port-level checks for the fan duty-cycle controller core, bound to the top level.
// Uses fdcc_pkg for the phase and register codes.
module fdcc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             relay_level,
   input logic [1:0]                       fan_state,
   input logic                             csr_we,
   input logic [fdcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [fdcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Tracks the relay polarity register as seen from the write port.
   logic polarity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= 1'b1;
      end else if (csr_we && (csr_index == fdcc_pkg::CSR_RELAY_ACTIVE_HIGH)) begin
         polarity_ff <= csr_wdata[0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(fan_state) && $stable(relay_level))
      else $error("stalled result changed");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("result missing two cycles after a transfer");

   a_relay_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> relay_level == ((fan_state == fdcc_pkg::PHASE_RUNNING) == polarity_ff))
      else $error("relay level does not match state and polarity");

endmodule

bind fan_duty_cycle_controller_core fdcc_checker u_fdcc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .relay_level (rsp_ch.relay_level),
   .fan_state   (rsp_ch.fan_state),
   .csr_we      (csr_we),
   .csr_index   (csr_index),
   .csr_wdata   (csr_wdata)
);

@@ tb/fdcc_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the fan duty-cycle controller testbench: a cycle-free model of the
// phase machine, the queue of predicted results and the mismatch counter.
// Depends on fdcc_pkg for the phase, event and register codes.
package fdcc_tb_pkg;
   import fdcc_pkg::*;

   typedef struct packed {
      logic      relay_level;
      phase_type fan_state;
   } fan_outcome_type;

   class fan_scoreboard;
      logic              started;
      logic              relay_active_high;
      logic [31:0]       cooldown_ms;
      logic [31:0]       run_ms;
      logic [7:0]        auto_mode_code;
      phase_type         phase;
      logic [31:0]       phase_start_ms;
      logic              resume_armed;
      fan_outcome_type   outcome_q[$];
      int unsigned       errors;
      int unsigned       events_seen;
      int unsigned       results_seen;
      int unsigned       phase_hits[4];

      function new();
         started           = 1'b0;
         relay_active_high = 1'b1;
         cooldown_ms       = '0;
         run_ms            = '0;
         auto_mode_code    = '0;
         phase             = PHASE_DISABLED;
         phase_start_ms    = '0;
         resume_armed      = 1'b0;
         errors            = 0;
         events_seen       = 0;
         results_seen      = 0;
         foreach (phase_hits[i]) phase_hits[i] = 0;
      endfunction

      function void switch_off();
         resume_armed   = 1'b0;
         phase          = PHASE_DISABLED;
         phase_start_ms = '0;
      endfunction

      function void enter_phase(phase_type next, logic [31:0] now_ms);
         phase          = next;
         phase_start_ms = now_ms;
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_STARTED: begin
               started = data[0];
               // Starting the controller always begins from the off state.
               if (started) switch_off();
            end
            CSR_RELAY_ACTIVE_HIGH: relay_active_high = data[0];
            CSR_COOLDOWN_MS:       cooldown_ms = data[31:0];
            CSR_RUN_MS:            run_ms = data[31:0];
            CSR_AUTO_MODE_CODE:    auto_mode_code = data[7:0];
            default: ;
         endcase
      endfunction

      // Advance the phase machine by one event and queue the result it produces.
      function void note_event(event_type ev);
         logic [31:0]     elapsed;
         fan_outcome_type outcome;
         elapsed = ev.now_ms - phase_start_ms;
         if (started) begin
            case (ev.func)
               FUNC_TICK: begin
                  if (ev.mode != auto_mode_code) begin
                     switch_off();
                  end else begin
                     case (phase)
                        PHASE_DISABLED: enter_phase(PHASE_COOLDOWN, ev.now_ms);
                        PHASE_PAUSED: begin
                           if (resume_armed) begin
                              resume_armed = 1'b0;
                              enter_phase(PHASE_COOLDOWN, ev.now_ms);
                           end
                        end
                        PHASE_COOLDOWN: begin
                           if (elapsed >= cooldown_ms) enter_phase(PHASE_RUNNING, ev.now_ms);
                        end
                        default: begin
                           if (elapsed >= run_ms) enter_phase(PHASE_COOLDOWN, ev.now_ms);
                        end
                     endcase
                  end
               end
               FUNC_OBSTACLE: begin
                  if (phase != PHASE_DISABLED) begin
                     resume_armed = 1'b0;
                     enter_phase(PHASE_PAUSED, ev.now_ms);
                  end
               end
               FUNC_TURN_DONE: begin
                  if (phase == PHASE_PAUSED) resume_armed = 1'b1;
               end
               default: switch_off();
            endcase
         end
         outcome.relay_level = ((phase == PHASE_RUNNING) == relay_active_high);
         outcome.fan_state   = phase;
         outcome_q.push_back(outcome);
         events_seen++;
         phase_hits[phase]++;
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_result(logic relay_level, logic [1:0] fan_state);
         fan_outcome_type want;
         results_seen++;
         if (outcome_q.size() == 0) begin
            report($sformatf("result with nothing predicted: relay %0b state %0d",
                             relay_level, fan_state));
         end else begin
            want = outcome_q.pop_front();
            if (relay_level !== want.relay_level)
               report($sformatf("result %0d relay_level %0b, predicted %0b",
                                results_seen, relay_level, want.relay_level));
            if (fan_state !== want.fan_state)
               report($sformatf("result %0d fan_state %0d, predicted %0d",
                                results_seen, fan_state, want.fan_state));
         end
      endtask
   endclass

endpackage

@@ tb/fan_duty_cycle_controller_core_tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench of the fan duty-cycle controller core: directed and random events
// with random idling on both channels, checked against the scoreboard in fdcc_tb_pkg.
// Depends on fdcc_pkg, fdcc_if, fdcc_tb_pkg and the RTL of the core.
module fan_duty_cycle_controller_core_tb;
   import fdcc_pkg::*;
   import fdcc_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INDEX_W'(CSR_AUTO_MODE_CODE + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fdcc_req_if req_ch ();
   fdcc_rsp_if rsp_ch ();

   fan_scoreboard board;
   logic [31:0]   wall_ms;
   logic          calm;
   int unsigned   settings_count;
   int unsigned   cycle_count;

   fan_duty_cycle_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, board.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.relay_level, rsp_ch.fan_state);
   end

   // Result side: ready drops in bursts of random length, except in the calm phase.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Step the millisecond clock: mostly small steps around the configured durations,
   // now and then a repeat of the same time or a jump anywhere in the 32-bit range.
   function automatic logic [31:0] next_ms();
      int unsigned span;
      int unsigned pick;
      span = (board.cooldown_ms > board.run_ms) ? board.cooldown_ms : board.run_ms;
      if (span > 1000) span = 1000;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         wall_ms = wall_ms + $urandom;
      else if (pick != 1)
         wall_ms = wall_ms + $urandom_range(0, span + 2);
      return wall_ms;
   endfunction

   task automatic send_event(func_type func, logic [7:0] mode, logic [31:0] now_ms);
      event_type ev;
      ev.func   = func;
      ev.mode   = mode;
      ev.now_ms = now_ms;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.func   <= func;
      req_ch.mode   <= mode;
      req_ch.now_ms <= now_ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_event(ev);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted result has been taken.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      board.write_reg(index, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic started, logic active_high, logic [31:0] cooldown,
                            logic [31:0] run, logic [7:0] auto_code);
      settle();
      write_reg(CSR_RELAY_ACTIVE_HIGH, {31'd0, active_high});
      write_reg(CSR_COOLDOWN_MS, cooldown);
      write_reg(CSR_RUN_MS, run);
      write_reg(CSR_AUTO_MODE_CODE, {24'd0, auto_code});
      // Writes to unmapped indexes must leave every register alone.
      write_reg(CSR_INDEX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)), $urandom);
      write_reg(CSR_STARTED, {31'd0, started});
      settings_count++;
   endtask

   task automatic run_random(int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned waits;
      logic [7:0]  other;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_event(FUNC_TICK, board.auto_mode_code, next_ms());
            sent++;
         end else if (pick < 70) begin
            other = 8'($urandom);
            if (other == board.auto_mode_code) other = ~other;
            send_event(FUNC_TICK, other, next_ms());
            sent++;
         end else if (pick < 82) begin
            // Obstacle, some ticks while paused, maybe a second obstacle, then resume.
            send_event(FUNC_OBSTACLE, 8'($urandom), next_ms());
            waits = $urandom_range(0, 2);
            repeat (waits) send_event(FUNC_TICK, board.auto_mode_code, next_ms());
            if ($urandom_range(0, 3) == 0) begin
               send_event(FUNC_TURN_DONE, 8'($urandom), next_ms());
               send_event(FUNC_OBSTACLE, 8'($urandom), next_ms());
               sent += 2;
            end
            send_event(FUNC_TURN_DONE, 8'($urandom), next_ms());
            send_event(FUNC_TICK, board.auto_mode_code, next_ms());
            sent += waits + 3;
         end else if (pick < 88) begin
            send_event(FUNC_TURN_DONE, 8'($urandom), next_ms());
            sent++;
         end else if (pick < 93) begin
            send_event(FUNC_FORCE_OFF, 8'($urandom), next_ms());
            sent++;
         end else begin
            send_event(func_type'($urandom_range(0, 3)), 8'($urandom), $urandom);
            sent++;
         end
      end
   endtask

   initial begin
      board          = new();
      calm           = 1'b0;
      settings_count = 0;
      cycle_count    = 0;
      wall_ms        = $urandom;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_TICK;
      req_ch.mode    = '0;
      req_ch.now_ms  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Before the controller is started, events only report the off level.
      send_event(FUNC_TICK, 8'h00, 32'd0);
      send_event(FUNC_OBSTACLE, 8'h00, 32'd5);

      configure(1'b1, 1'b1, 32'd3, 32'd5, 8'hA5);
      send_event(FUNC_TICK, 8'h00, 32'd0);
      send_event(FUNC_OBSTACLE, 8'hA5, 32'd10);
      send_event(FUNC_TURN_DONE, 8'hA5, 32'd11);
      send_event(FUNC_TICK, 8'hA5, 32'd100);
      send_event(FUNC_TICK, 8'hA5, 32'd102);
      send_event(FUNC_TICK, 8'hA5, 32'd103);
      send_event(FUNC_TICK, 8'hA5, 32'd108);
      send_event(FUNC_OBSTACLE, 8'hA5, 32'd109);
      send_event(FUNC_TICK, 8'hA5, 32'd200);
      send_event(FUNC_TURN_DONE, 8'hA5, 32'd201);
      send_event(FUNC_OBSTACLE, 8'hA5, 32'd202);
      send_event(FUNC_TICK, 8'hA5, 32'd203);
      send_event(FUNC_TURN_DONE, 8'hA5, 32'd204);
      send_event(FUNC_TICK, 8'hA5, 32'd206);
      send_event(FUNC_FORCE_OFF, 8'hA5, 32'd207);
      send_event(FUNC_TICK, 8'hA5, 32'hFFFF_FFFE);
      send_event(FUNC_TICK, 8'hA5, 32'd1);
      send_event(FUNC_TICK, 8'hFF, 32'd2);

      // Longest cooldown ends only at an elapsed time of all ones; a zero run ends at once.
      configure(1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0, 8'h00);
      send_event(FUNC_TICK, 8'h00, 32'hFFFF_FFFF);
      send_event(FUNC_TICK, 8'h00, 32'hFFFF_FFFD);
      send_event(FUNC_TICK, 8'h00, 32'hFFFF_FFFE);
      send_event(FUNC_TICK, 8'h00, 32'hFFFF_FFFE);
      send_event(FUNC_FORCE_OFF, 8'hFF, 32'd0);

      configure(1'b1, 1'b1, $urandom_range(0, 20), $urandom_range(0, 20), 8'($urandom));
      run_random(120);
      configure(1'b1, 1'b0, 32'd0, 32'd0, 8'hFF);
      run_random(120);
      configure(1'b1, 1'b1, 32'hFFFF_FFFF, $urandom_range(1, 10), 8'h00);
      run_random(100);
      configure(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 20), $urandom_range(0, 20),
                8'($urandom));
      run_random(25);
      configure(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 40), $urandom,
                8'($urandom));
      run_random(120);

      settle();
      calm = 1'b1;
      configure(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom_range(0, 15),
                8'($urandom));
      run_random(190);

      settle();
      repeat (8) @(negedge clock);
      $display("Checked %0d results from %0d events over %0d register settings",
               board.results_seen, board.events_seen, settings_count);
      $display("Phase after each event: disabled %0d, cooldown %0d, running %0d, paused %0d",
               board.phase_hits[PHASE_DISABLED], board.phase_hits[PHASE_COOLDOWN],
               board.phase_hits[PHASE_RUNNING], board.phase_hits[PHASE_PAUSED]);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Mismatches: %0d", board.errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/fdcc_pkg.sv
rtl/core/fdcc_if.sv
rtl/core/fdcc_engine.sv
rtl/core/fan_duty_cycle_controller_core.sv
rtl/core/fdcc_checker.sv
tb/fdcc_tb_pkg.sv
tb/fan_duty_cycle_controller_core_tb.sv
